// ----- rtl/dmkr_pkg.sv -----
`timescale 1ns / 1ps
// dmkr_pkg: constants, types and the key map builder of the duplex matrix key report block
// used by every module under rtl
package dmkr_pkg;

  localparam int MATRIX_ROWS    = 4;
  localparam int MATRIX_COLS    = 6;
  localparam int REPORT_SLOTS   = 6;

  localparam int SENSE_BITS     = 24;
  localparam int KEY_ROW_STRIDE = 12;
  localparam int KEY_MAP_BITS   = 8 * 6;

  localparam int LANE_BITS      = KEY_ROW_STRIDE;
  localparam int NUM_LANES      = (KEY_MAP_BITS + LANE_BITS - 1) / LANE_BITS;
  localparam int PADDED_BITS    = NUM_LANES * LANE_BITS;
  localparam int LANE_POS_W     = (LANE_BITS > 1) ? $clog2(LANE_BITS) : 1;
  localparam int SLOT_W         = $clog2(REPORT_SLOTS + 1);

  localparam logic [7:0] TERMINATOR = 8'hFF;
  localparam logic [7:0] EMPTY_SLOT = 8'h00;

  typedef logic [KEY_MAP_BITS-1:0] key_map_t;

  typedef struct packed {
    logic                  found;
    logic [LANE_POS_W-1:0] pos;
  } lane_stat_t;

  typedef struct packed {
    logic                 any;
    logic [7:0]           key_num;
    logic [NUM_LANES-1:0] take;
  } pick_t;

  // active-low readings from both drive directions folded into one pressed map
  function automatic key_map_t build_map(input logic [SENSE_BITS-1:0] rowdrive,
                                         input logic [SENSE_BITS-1:0] coldrive);
    key_map_t m;
    int       sense_i;
    int       key_i;
    m = '0;
    for (int r = 0; r < MATRIX_ROWS; r++) begin
      for (int c = 0; c < MATRIX_COLS; c++) begin
        sense_i = r * MATRIX_COLS + c;
        key_i   = c * 2 + r * KEY_ROW_STRIDE;
        if (sense_i < SENSE_BITS) begin
          if (key_i < KEY_MAP_BITS) begin
            m[key_i] = m[key_i] | ~rowdrive[sense_i];
          end
          if (key_i + 1 < KEY_MAP_BITS) begin
            m[key_i + 1] = m[key_i + 1] | ~coldrive[sense_i];
          end
        end
      end
    end
    return m;
  endfunction

endpackage

// ----- rtl/duplex_matrix_key_report_top.sv -----
`timescale 1ns / 1ps
// duplex_matrix_key_report_top: snapshot holding register, report sequencer, output register
// depends on dmkr_pkg, dmkr_lane, dmkr_merge
//
// usage
// - input channel: one transaction carries a snapshot of the duplex matrix as two
//   active-low sense vectors (rows driven, columns driven); a low bit is a pressed key
// - output channel: seven byte transactions per snapshot, the numbers of the first six
//   pressed keys in ascending order, zero for empty slots, then 0xff with last_byte set
// - a snapshot moves from the holding register into the lane registers, and the first
//   report byte is registered in the output register; one report byte per cycle
//   while the output is not stalled; the next snapshot waits in a holding register
//   and its report follows the terminator without a gap
// - the pressed map is split into one lane per matrix row; each lane finds its lowest
//   pressed key and the merge picks the lowest lane
// - in_stall is high while the holding register is full
// - a stalled output keeps its byte; the sequencer and the lanes pause with it
// - reset drops any held snapshot and any report in progress
module duplex_matrix_key_report_top
  import dmkr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SENSE_BITS-1:0] column_levels_rowdrive,
  input  logic [SENSE_BITS-1:0] row_levels_coldrive,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            report_byte,
  output logic                  last_byte
);

  logic                       hold_valid;
  key_map_t                   hold_map;
  logic                       busy;
  logic [SLOT_W-1:0]          slot;
  logic                       in_fire;
  logic                       out_free;
  logic                       emit;
  logic                       at_term;
  logic                       load;
  logic                       do_take;
  logic [PADDED_BITS-1:0]     padded;
  lane_stat_t [NUM_LANES-1:0] stats;
  pick_t                      pick;

  assign in_stall = hold_valid;
  assign in_fire  = in_valid && !hold_valid;
  assign out_free = !out_valid || !out_stall;
  assign emit     = busy && out_free;
  assign at_term  = (slot == SLOT_W'(REPORT_SLOTS));
  assign load     = hold_valid && (!busy || (emit && at_term));
  assign do_take  = emit && !at_term && pick.any;
  assign padded   = PADDED_BITS'(hold_map);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_map <= build_map(column_levels_rowdrive, row_levels_coldrive);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_fire) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  // lanes, one slice of the map each
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    dmkr_lane u_lane (
      .clk    (clk),
      .load   (load),
      .seg_in (padded[l*LANE_BITS +: LANE_BITS]),
      .take   (do_take && pick.take[l]),
      .stat   (stats[l])
    );
  end

  dmkr_merge u_merge (
    .stats (stats),
    .pick  (pick)
  );

  // report sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (load) begin
      busy <= 1'b1;
      slot <= '0;
    end else if (emit) begin
      if (at_term) begin
        busy <= 1'b0;
      end
      slot <= slot + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      priority if (at_term) begin
        report_byte <= TERMINATOR;
        last_byte   <= 1'b1;
      end else if (pick.any) begin
        report_byte <= pick.key_num;
        last_byte   <= 1'b0;
      end else begin
        report_byte <= EMPTY_SLOT;
        last_byte   <= 1'b0;
      end
    end
  end

  // checks
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> slot <= SLOT_W'(REPORT_SLOTS))
    else $error("slot counter out of range");

  a_term_last: assert property (@(posedge clk) disable iff (rst)
    (emit && at_term) |=> (out_valid && last_byte && report_byte == TERMINATOR))
    else $error("terminator not marked last");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_byte) |-> report_byte <= 8'(KEY_MAP_BITS))
    else $error("key number out of range");

  a_one_lane: assert property (@(posedge clk) disable iff (rst)
    busy |-> ($onehot0(pick.take) && (pick.any == (pick.take != '0))))
    else $error("merge selected more than one lane");

endmodule

// ----- rtl/dmkr_lane.sv -----
`timescale 1ns / 1ps
// dmkr_lane: holds one slice of the pressed map and finds its lowest pressed key
// depends on dmkr_pkg
module dmkr_lane
  import dmkr_pkg::*;
(
  input  logic                 clk,
  input  logic                 load,
  input  logic [LANE_BITS-1:0] seg_in,
  input  logic                 take,
  output lane_stat_t           stat
);

  logic [LANE_BITS-1:0] seg;

  // take clears the lowest set bit
  always_ff @(posedge clk) begin
    if (load) begin
      seg <= seg_in;
    end else if (take) begin
      seg <= seg & (seg - LANE_BITS'(1));
    end
  end

  always_comb begin
    stat.found = |seg;
    stat.pos   = '0;
    for (int i = LANE_BITS - 1; i >= 0; i--) begin
      if (seg[i]) begin
        stat.pos = LANE_POS_W'(i);
      end
    end
  end

endmodule

// ----- rtl/dmkr_merge.sv -----
`timescale 1ns / 1ps
// dmkr_merge: picks the lowest lane with a pressed key and forms the key number
// depends on dmkr_pkg
module dmkr_merge
  import dmkr_pkg::*;
(
  input  lane_stat_t [NUM_LANES-1:0] stats,
  output pick_t                      pick
);

  always_comb begin
    pick = '0;
    for (int l = NUM_LANES - 1; l >= 0; l--) begin
      if (stats[l].found) begin
        pick.any     = 1'b1;
        pick.key_num = 8'(l * LANE_BITS + int'(stats[l].pos) + 1);
        pick.take    = NUM_LANES'(1) << l;
      end
    end
  end

endmodule
